[rtl/shc_pkg.sv]
// Shared constants, tables and types for the sponge hash permutation core.
package shc_pkg;

  localparam int unsigned NumWords   = 40;
  localparam int unsigned MaxRounds  = 40;
  localparam int unsigned RoundDef   = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERM,
    ST_PAD1,
    ST_PAD2,
    ST_SQUEEZE
  } state_t;

  typedef logic [63:0] word_t;

  localparam logic [31:0] ROUND_KEY [MaxRounds] = '{
    32'h2c387d69, 32'h988cc9dd, 32'hf0e4a1b5, 32'h21357064,
    32'h8397d2c6, 32'hc7d39682, 32'h4f5b1e0a, 32'h5e4a0f1b,
    32'h7c682d39, 32'h392d687c, 32'hb3a7e2f6, 32'ha7b3f6e2,
    32'h8e9adfcb, 32'hdcc88d99, 32'h786c293d, 32'h30246175,
    32'ha1b5f0e4, 32'h8296d3c7, 32'hc5d19480, 32'h4a5e1b0f,
    32'h55410410, 32'h6b7f3a2e, 32'h17034652, 32'heffbbeaa,
    32'h1f0b4e5a, 32'hffebaeba, 32'h3f2b6e7a, 32'hbfabeefa,
    32'hbeaaeffb, 32'hbca8edf9, 32'hb9ade8fc, 32'hb2a6e3f7,
    32'ha5b1f4e0, 32'h8b9fdace, 32'hd7c38692, 32'h6f7b3e2a,
    32'h1e0a4f5b, 32'hfde9acb8, 32'h3a2e6b7f, 32'hb4a0e5f1
  };

  localparam logic [3:0] NIB_MAP [16] = '{
    4'h1, 4'h0, 4'h5, 4'h6, 4'hC, 4'h9, 4'h2, 4'h8,
    4'hA, 4'h7, 4'h3, 4'hF, 4'hE, 4'hB, 4'h4, 4'hD
  };

  localparam logic [9:0] MIX_ROWS [10] = '{
    10'h1C5, 10'h334, 10'h269, 10'h0F2, 10'h38A,
    10'h2A7, 10'h1B9, 10'h2DC, 10'h16E, 10'h353
  };

  localparam logic [1:0] ROW_PICK [10][4] = '{
    '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd0}, '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd0, 2'd1, 2'd2, 2'd3}
  };

  localparam logic [3:0] HALF_SWAP [10] = '{
    4'hF, 4'h0, 4'h0, 4'hF, 4'hF, 4'h0, 4'hA, 4'hA, 4'h5, 4'h5
  };

  localparam logic [2:0] HALF_ROT [10] = '{
    3'd4, 3'd1, 3'd3, 3'd0, 3'd7, 3'd0, 3'd5, 3'd3, 3'd5, 3'd1
  };

  function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] d;
    d = {x, x} >> s;
    return d[31:0];
  endfunction

endpackage

[rtl/shc_if.sv]
// Valid/ready channel interfaces for message, digest and configuration words.
interface shc_msg_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [6:0]  valid_bits;
  logic        last;
  modport source (output valid, message_word, valid_bits, last, input ready);
  modport sink (input valid, message_word, valid_bits, last, output ready);
endinterface

interface shc_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        last_word;
  modport source (output valid, digest_word, last_word, input ready);
  modport sink (input valid, digest_word, last_word, output ready);
endinterface

interface shc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] digest_size;
  modport source (output valid, digest_size, input ready);
  modport sink (input valid, digest_size, output ready);
endinterface

[rtl/shc_round.sv]
// One permutation round: nibble S-box, column mix, row shuffle, round key.
module shc_round (
  input  logic [63:0] st_in  [shc_pkg::NumWords],
  input  logic [31:0] key,
  output logic [63:0] st_out [shc_pkg::NumWords]
);

  logic [63:0] sb  [shc_pkg::NumWords];
  logic [63:0] mix [shc_pkg::NumWords];

  always_comb begin
    for (int i = 0; i < 40; i++) begin
      for (int k = 0; k < 16; k++) begin
        sb[i][4*k +: 4] = shc_pkg::NIB_MAP[st_in[i][4*k +: 4]];
      end
    end
  end

  // each output row is the XOR of the input rows flagged in its mix mask
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 10; i++) begin
        mix[j + 4*i] = '0;
        for (int k = 0; k < 10; k++) begin
          if (shc_pkg::MIX_ROWS[i][k]) mix[j + 4*i] = mix[j + 4*i] ^ sb[j + 4*k];
        end
      end
    end
  end

  always_comb begin
    logic [63:0] x;
    logic [4:0]  s;
    x = '0;
    s = '0;
    for (int i = 0; i < 10; i++) begin
      s = {shc_pkg::HALF_ROT[i], 2'b00};
      for (int j = 0; j < 4; j++) begin
        x = mix[4*i + 32'(shc_pkg::ROW_PICK[i][j])];
        if (shc_pkg::HALF_SWAP[i][j]) x = {x[31:0], x[63:32]};
        st_out[4*i + j] = {shc_pkg::rot_right(x[63:32], s), shc_pkg::rot_right(x[31:0], s)};
      end
    end
    st_out[0][63:32] = st_out[0][63:32] ^ key;
  end

endmodule

[rtl/sponge_hash_2560bit_permutation_core.sv]
// Sponge hash over a 2560-bit state. A message word that does not fill a rate block is absorbed
// directly; the word that completes a block, and the padding and squeeze steps, run the
// permutation through one shared round unit at one round per cycle, and the block is not ready
// during it. The last word adds one or two permutations, the padding steps and the digest words;
// at 1024-bit digests a further permutation sits between the two squeeze blocks. Configuration
// is taken only while the block is idle, ahead of a message word offered in the same cycle, and
// clears the state.
module sponge_hash_2560bit_permutation_core #(
  parameter int unsigned ROUND_COUNT = shc_pkg::RoundDef
) (
  input  logic     clk,
  input  logic     rst,
  shc_msg_if.sink  message,
  shc_dig_if.source digest,
  shc_cfg_if.sink  cfg
);

  logic [63:0] st      [shc_pkg::NumWords];
  logic [63:0] rnd_out [shc_pkg::NumWords];

  shc_pkg::state_t state, state_next, ret;
  logic [1:0]  dsize;
  logic [4:0]  wp;
  logic [10:0] pos;
  logic [5:0]  rnd;
  logic [4:0]  sq_n;
  logic [4:0]  sq_done;
  logic        ovalid;
  logic [63:0] oword;
  logic        olast;

  logic [1:0]  dsel;
  logic [4:0]  rate;
  logic [4:0]  outw;
  logic [10:0] rbits;
  logic        acc;
  logic        rnd_end;
  logic        load;
  logic        blk_end;
  logic        sq_end;
  logic [6:0]  vsat;
  logic [63:0] mword;
  logic [10:0] lpos;

  shc_round u_round (
    .st_in  (st),
    .key    (shc_pkg::ROUND_KEY[rnd]),
    .st_out (rnd_out)
  );

  always_comb begin
    dsel  = (dsize == 2'd3) ? 2'd2 : dsize;
    rate  = 5'(5'd24 - {dsel, 3'b000});
    outw  = 5'(5'd8 + {1'b0, dsel, 2'b00});
    rbits = {rate, 6'd0};
    vsat  = (message.valid_bits > 7'd64) ? 7'd64 : message.valid_bits;
    mword = message.message_word & ~({64{1'b1}} >> vsat);
    lpos  = 11'({wp, 6'd0} + {4'd0, vsat});
  end

  // outputs of the sequencer
  always_comb begin
    cfg.ready     = (state == shc_pkg::ST_IDLE);
    message.ready = (state == shc_pkg::ST_IDLE) && !cfg.valid;
    acc           = message.valid && message.ready;
    rnd_end       = (32'(rnd) == ROUND_COUNT - 1);
    load          = (state == shc_pkg::ST_SQUEEZE) && (!ovalid || digest.ready);
    blk_end       = (sq_n + 5'd1 == rate);
    sq_end        = (sq_done + 5'd1 == outw);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      shc_pkg::ST_IDLE: begin
        if (acc) begin
          if (message.last) begin
            state_next = (lpos >= rbits) ? shc_pkg::ST_PERM : shc_pkg::ST_PAD1;
          end else if (wp + 5'd1 >= rate) begin
            state_next = shc_pkg::ST_PERM;
          end
        end
      end
      shc_pkg::ST_PERM: if (rnd_end) state_next = ret;
      shc_pkg::ST_PAD1: state_next = (pos == rbits - 11'd1) ? shc_pkg::ST_PERM : shc_pkg::ST_PAD2;
      shc_pkg::ST_PAD2: state_next = shc_pkg::ST_PERM;
      shc_pkg::ST_SQUEEZE: begin
        if (load && (sq_end || blk_end)) begin
          state_next = sq_end ? shc_pkg::ST_IDLE : shc_pkg::ST_PERM;
        end
      end
      default: state_next = shc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shc_pkg::ST_IDLE;
      ret   <= shc_pkg::ST_IDLE;
      dsize <= 2'd0;
      wp    <= '0;
      rnd   <= '0;
      sq_n  <= '0;
      sq_done <= '0;
      ovalid <= 1'b0;
      for (int i = 0; i < 40; i++) st[i] <= '0;
    end else begin
      state <= state_next;
      if (load) ovalid <= 1'b1;
      else if (digest.ready) ovalid <= 1'b0;
      unique case (state)
        shc_pkg::ST_IDLE: begin
          if (acc) begin
            if (message.last) begin
              st[{1'b0, wp}] <= st[{1'b0, wp}] ^ mword;
              if (lpos >= rbits) begin
                pos <= '0;
                ret <= shc_pkg::ST_PAD1;
              end else begin
                pos <= lpos;
              end
              rnd <= '0;
            end else begin
              st[{1'b0, wp}] <= st[{1'b0, wp}] ^ message.message_word;
              wp  <= (wp + 5'd1 >= rate) ? 5'd0 : wp + 5'd1;
              ret <= shc_pkg::ST_IDLE;
              rnd <= '0;
            end
          end
        end
        shc_pkg::ST_PERM: begin
          st  <= rnd_out;
          rnd <= rnd_end ? 6'd0 : rnd + 6'd1;
        end
        shc_pkg::ST_PAD1: begin
          st[{1'b0, pos[10:6]}][~pos[5:0]] <= ~st[{1'b0, pos[10:6]}][~pos[5:0]];
          ret <= shc_pkg::ST_PAD2;
        end
        shc_pkg::ST_PAD2: begin
          st[{1'b0, rate - 5'd1}][0] <= ~st[{1'b0, rate - 5'd1}][0];
          ret     <= shc_pkg::ST_SQUEEZE;
          sq_n    <= '0;
          sq_done <= '0;
        end
        shc_pkg::ST_SQUEEZE: begin
          if (load) begin
            oword   <= st[{1'b0, sq_n}];
            olast   <= sq_end;
            sq_done <= sq_done + 5'd1;
            sq_n    <= blk_end ? 5'd0 : sq_n + 5'd1;
            if (sq_end) begin
              // run over: drop the state for the next message
              for (int i = 0; i < 40; i++) st[i] <= '0;
              wp <= '0;
            end
          end
        end
        default: ;
      endcase
      if (cfg.valid && cfg.ready) begin
        dsize <= cfg.digest_size;
        wp    <= '0;
        for (int i = 0; i < 40; i++) st[i] <= '0;
      end
    end
  end

  assign digest.valid       = ovalid;
  assign digest.digest_word = oword;
  assign digest.last_word   = olast;

endmodule

[verif/tb_chk.sv]
`timescale 1ns / 1ps
// Checker: watches the message, digest and config channels, predicts digests and compares.
module tb_chk (
  input  logic      clk,
  input  logic      rst,
  shc_msg_if        message,
  shc_dig_if        digest,
  shc_cfg_if        cfg,
  output int        fail_count,
  output int        pending,
  output int        digest_count
);

  typedef struct packed {
    shc_pkg::word_t dword;
    logic  lastw;
  } digest_t;

  shc_pkg::word_t sponge [shc_pkg::NumWords];
  int        word_pos;
  logic [1:0] size_sel;
  digest_t   digest_q [$];

  function automatic shc_pkg::word_t sub_word(input shc_pkg::word_t x);
    shc_pkg::word_t y;
    for (int k = 0; k < 64; k += 4) y[k +: 4] = shc_pkg::NIB_MAP[x[k +: 4]];
    return y;
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int s);
    if (s == 0) return x;
    return (x >> s) | (x << (32 - s));
  endfunction

  task automatic permute_sponge();
    shc_pkg::word_t mixed [shc_pkg::NumWords];
    shc_pkg::word_t acc, x;
    int s;
    for (int r = 0; r < 40; r++) begin
      for (int i = 0; i < shc_pkg::NumWords; i++) sponge[i] = sub_word(sponge[i]);
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 10; i++) begin
          acc = '0;
          for (int k = 0; k < 10; k++)
            if (shc_pkg::MIX_ROWS[i][k]) acc ^= sponge[j + 4 * k];
          mixed[j + 4 * i] = acc;
        end
      end
      for (int i = 0; i < 10; i++) begin
        s = 4 * shc_pkg::HALF_ROT[i];
        for (int j = 0; j < 4; j++) begin
          x = mixed[4 * i + shc_pkg::ROW_PICK[i][j]];
          if (shc_pkg::HALF_SWAP[i][j]) x = {x[31:0], x[63:32]};
          sponge[4 * i + j] = {rotr32(x[63:32], s), rotr32(x[31:0], s)};
        end
      end
      sponge[0][63:32] ^= shc_pkg::ROUND_KEY[r];
    end
  endtask

  task automatic clear_sponge();
    for (int i = 0; i < shc_pkg::NumWords; i++) sponge[i] = '0;
    word_pos = 0;
  endtask

  task automatic flip(input int p);
    sponge[(p >> 6) % shc_pkg::NumWords][63 - (p & 63)] ^= 1'b1;
  endtask

  task automatic absorb_word(input shc_pkg::word_t w, input int vbits, input logic lst);
    int d, rate, outw, rbits, v, p, done, take;
    d = (size_sel > 2) ? 2 : size_sel;
    rate = 24 - 8 * d;
    outw = 8 + 4 * d;
    rbits = rate * 64;
    if (word_pos >= rate) word_pos = 0;
    if (!lst) begin
      sponge[word_pos] ^= w;
      word_pos++;
      if (word_pos >= rate) begin
        permute_sponge();
        word_pos = 0;
      end
      return;
    end
    v = (vbits > 64) ? 64 : vbits;
    if (v == 0) w = '0;
    else w &= ~64'd0 << (64 - v);
    sponge[word_pos] ^= w;
    p = word_pos * 64 + v;
    if (p >= rbits) begin
      permute_sponge();
      p = 0;
    end
    flip(p);
    if (p == rbits - 1) permute_sponge();
    flip(rbits - 1);
    permute_sponge();
    done = 0;
    while (done < outw) begin
      take = outw - done;
      if (take > rate) take = rate;
      for (int n = 0; n < take; n++)
        digest_q.push_back('{dword: sponge[n], lastw: (done + n == outw - 1)});
      done += take;
      if (done < outw) permute_sponge();
    end
    clear_sponge();
  endtask

  digest_t exp_d;

  always @(posedge clk) begin
    if (rst) begin
      clear_sponge();
      size_sel = 2'd0;
      fail_count = 0;
      digest_count = 0;
      digest_q.delete();
    end else begin
      if (digest.valid && digest.ready) begin
        digest_count++;
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", digest.digest_word);
          fail_count++;
        end else begin
          exp_d = digest_q.pop_front();
          if (digest.digest_word !== exp_d.dword) begin
            $error("digest_word expected %h actual %h", exp_d.dword, digest.digest_word);
            fail_count++;
          end
          if (digest.last_word !== exp_d.lastw) begin
            $error("last_word expected %b actual %b", exp_d.lastw, digest.last_word);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        size_sel = cfg.digest_size;
        clear_sponge();
      end
      if (message.valid && message.ready)
        absorb_word(message.message_word, message.valid_bits, message.last);
    end
    pending = digest_q.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, message and config stimulus, digest back-pressure, verdict.
module tb_top;

  logic clk, rst;
  int   fail_count, pending, digest_count;
  int   send_idle_pct, recv_stall_pct, hold_cycles;
  int   msgs_sent;

  shc_msg_if message ();
  shc_dig_if digest ();
  shc_cfg_if cfg ();

  sponge_hash_2560bit_permutation_core dut (
    .clk(clk), .rst(rst), .message(message), .digest(digest), .cfg(cfg)
  );

  tb_chk chk (
    .clk(clk), .rst(rst), .message(message), .digest(digest), .cfg(cfg),
    .fail_count(fail_count), .pending(pending), .digest_count(digest_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off counted in cycles.
  initial begin
    digest.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        digest.ready <= 1'b0;
      end else begin
        digest.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Leave valid high after the handshake; the next word or drain() updates it.
  task automatic send_word(input shc_pkg::word_t w, input logic [6:0] vb, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      message.valid <= 1'b0;
      @(posedge clk);
    end
    message.valid <= 1'b1;
    message.message_word <= w;
    message.valid_bits <= vb;
    message.last <= lst;
    @(posedge clk);
    while (!message.ready) @(posedge clk);
    if (lst) msgs_sent++;
  endtask

  task automatic drain();
    message.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_size(input logic [1:0] sz);
    drain();
    cfg.valid <= 1'b1;
    cfg.digest_size <= sz;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random message: mostly short, sometimes spanning blocks; random tail length.
  task automatic send_message(input int nwords);
    for (int i = 0; i < nwords; i++)
      send_word({$urandom, $urandom}, 7'($urandom_range(127)), 1'b0);
    send_word({$urandom, $urandom}, 7'($urandom_range(127)), 1'b1);
  endtask

  int n;

  initial begin
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    msgs_sent = 0;
    message.valid = 1'b0;
    message.message_word = '0;
    message.valid_bits = '0;
    message.last = 1'b0;
    cfg.valid = 1'b0;
    cfg.digest_size = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, full-length tails, saturated and masked counts.
    send_word('0, 7'd0, 1'b1);
    send_word('1, 7'd64, 1'b1);
    send_word('1, 7'd127, 1'b1);
    send_word(64'hA5A5_5A5A_F0F0_0F0F, 7'd1, 1'b1);
    send_word(64'h8000_0000_0000_0001, 7'd63, 1'b1);
    // Tails after seven words: one filling its last word, one leaving one bit for the pad.
    for (int i = 0; i < 7; i++) send_word('1, 7'd0, 1'b0);
    send_word('1, 7'd64, 1'b1);
    for (int i = 0; i < 7; i++) send_word('0, 7'd5, 1'b0);
    send_word('1, 7'd63, 1'b1);
    write_size(2'd2);
    send_word(64'h0123_4567_89AB_CDEF, 7'd32, 1'b1);
    write_size(2'd3);
    send_word('1, 7'd64, 1'b1);
    write_size(2'd1);
    for (int i = 0; i < 16; i++) send_word({$urandom, $urandom}, 7'd64, 1'b0);
    send_word('0, 7'd0, 1'b1);

    // Random phases across sizes and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_size(2'($urandom_range(3)));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 2) hold_cycles = 600;
      for (int m = 0; m < 11; m++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(4);
        send_message(n);
      end
      if (ph == 5) drain();
    end
    write_size(2'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_message(3);

    drain();
    $display("Hashed %0d messages across all digest sizes, %0d digest words checked.",
             msgs_sent, digest_count);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

[sim.f]
rtl/shc_pkg.sv
rtl/shc_if.sv
rtl/shc_round.sv
rtl/sponge_hash_2560bit_permutation_core.sv
verif/tb_chk.sv
verif/tb_top.sv
